// ===== rtl/stpd_pkg.sv =====
// ----------------------------------------------------------------------------
// stpd_pkg
// Shared types and constants of the sine-tracking PD current loop: step codes
// of the shared-multiplier sequence, the controller command bundle, register
// indexes, quarter-wave sine coefficients and 32-bit saturation.
// ----------------------------------------------------------------------------
package stpd_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned PROD_W      = 68;
	localparam int unsigned OPND_W      = 34;

	localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_SCALE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_P_GAIN_SCALE        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_D_GAIN_SCALE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_EFFORT_OFFSET       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_CENTER    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_AMPLITUDE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_SCALE       = 3'd6;

	localparam logic [30:0]        RST_POSITION_SCALE      = 31'd2059;
	localparam logic [30:0]        RST_P_GAIN_SCALE        = 31'd655360;
	localparam logic [30:0]        RST_D_GAIN_SCALE        = 31'd6554;
	localparam logic signed [31:0] RST_EFFORT_OFFSET       = 32'sd1966;
	localparam logic signed [31:0] RST_REFERENCE_CENTER    = 32'sd9830;
	localparam logic [30:0]        RST_REFERENCE_AMPLITUDE = 31'd3277;
	localparam logic [30:0]        RST_CURRENT_SCALE       = 31'd873813;

	localparam logic [17:0] PI_Q16        = 18'd205887;
	localparam logic [15:0] QUARTER_TURN  = 16'd16384;
	localparam logic [14:0] QUARTER_R     = 15'd16384;
	localparam logic [16:0] SINE_ONE      = 17'd65536;
	localparam logic [16:0] SINE_C0       = 17'd11;
	localparam logic [16:0] SINE_C1       = 17'd307;
	localparam logic [16:0] SINE_C2       = 17'd5223;
	localparam logic [16:0] SINE_C3       = 17'd42334;
	localparam logic [16:0] SINE_C4       = 17'd102944;

	localparam logic signed [PROD_W-1:0] S32_MAX_W = 68'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN_W = -68'sd2147483648;

	typedef enum logic [4:0] {
		ST_FH  = 5'd0,
		ST_FV  = 5'd1,
		ST_K   = 5'd2,
		ST_F   = 5'd3,
		ST_A   = 5'd4,
		ST_X2  = 5'd5,
		ST_H1  = 5'd6,
		ST_H2  = 5'd7,
		ST_H3  = 5'd8,
		ST_H4  = 5'd9,
		ST_S   = 5'd10,
		ST_DH  = 5'd11,
		ST_API = 5'd12,
		ST_DV  = 5'd13,
		ST_PG  = 5'd14,
		ST_DG  = 5'd15,
		ST_PE  = 5'd16,
		ST_DE  = 5'd17,
		ST_IQ  = 5'd18
	} step_t;

	typedef struct packed {
		logic  capture;
		logic  run;
		step_t step;
		logic  pass;
		logic  load_out;
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX_W) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S32_MIN_W) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/stpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// stpd_ctrl
// Sequencer of the PD current loop: takes an input transfer, walks the step
// sequence of the shared multiplier, and hands the result to the output
// register once that register is free.
// ----------------------------------------------------------------------------
module stpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           motor_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output stpd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		CS_IDLE = 3'b001,
		CS_RUN  = 3'b010,
		CS_HOLD = 3'b100
	} ctrl_state_t;

	ctrl_state_t     state_q, state_d;
	stpd_pkg::step_t step_q, step_d;
	logic            pass_q, pass_d;
	logic            out_valid_q, out_valid_d;
	logic            out_free;

	assign in_ready  = (state_q == CS_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		pass_d       = pass_q;
		cmd.capture  = 1'b0;
		cmd.run      = (state_q == CS_RUN);
		cmd.step     = step_q;
		cmd.pass     = pass_q;
		cmd.load_out = 1'b0;
		case (state_q)
			CS_IDLE: begin
				if (in_valid && motor_ready) begin
					cmd.capture = 1'b1;
					state_d     = CS_RUN;
					step_d      = stpd_pkg::ST_FH;
					pass_d      = 1'b0;
				end
			end
			CS_RUN: begin
				case (step_q)
					stpd_pkg::ST_FH:  step_d = stpd_pkg::ST_FV;
					stpd_pkg::ST_FV:  step_d = stpd_pkg::ST_K;
					stpd_pkg::ST_K:   step_d = stpd_pkg::ST_F;
					stpd_pkg::ST_F:   step_d = stpd_pkg::ST_A;
					stpd_pkg::ST_A:   step_d = stpd_pkg::ST_X2;
					stpd_pkg::ST_X2:  step_d = stpd_pkg::ST_H1;
					stpd_pkg::ST_H1:  step_d = stpd_pkg::ST_H2;
					stpd_pkg::ST_H2:  step_d = stpd_pkg::ST_H3;
					stpd_pkg::ST_H3:  step_d = stpd_pkg::ST_H4;
					stpd_pkg::ST_H4:  step_d = stpd_pkg::ST_S;
					stpd_pkg::ST_S: begin
						if (!pass_q) begin
							step_d = stpd_pkg::ST_K;
							pass_d = 1'b1;
						end else begin
							step_d = stpd_pkg::ST_DH;
						end
					end
					stpd_pkg::ST_DH:  step_d = stpd_pkg::ST_API;
					stpd_pkg::ST_API: step_d = stpd_pkg::ST_DV;
					stpd_pkg::ST_DV:  step_d = stpd_pkg::ST_PG;
					stpd_pkg::ST_PG:  step_d = stpd_pkg::ST_DG;
					stpd_pkg::ST_DG:  step_d = stpd_pkg::ST_PE;
					stpd_pkg::ST_PE:  step_d = stpd_pkg::ST_DE;
					stpd_pkg::ST_DE:  step_d = stpd_pkg::ST_IQ;
					stpd_pkg::ST_IQ:  state_d = CS_HOLD;
					default:          state_d = CS_IDLE;
				endcase
			end
			CS_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			step_q      <= stpd_pkg::ST_FH;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			pass_q      <= pass_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// ===== rtl/stpd_datapath.sv =====
// ----------------------------------------------------------------------------
// stpd_datapath
// Registers, configuration and the single shared 34x34 signed multiplier of
// the PD current loop. Each step selects two operands, multiplies, and
// writes shifted, summed or saturated results back into registers.
// ----------------------------------------------------------------------------
module stpd_datapath #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [stpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [stpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  stpd_pkg::cmd_t                         cmd,
	input  logic signed [31:0]                     motor_position,
	input  logic signed [31:0]                     motor_velocity,
	input  logic [15:0]                            slider_a,
	input  logic [15:0]                            slider_b,
	input  logic [15:0]                            trajectory_phase,
	output logic signed [31:0]                     current_command,
	output logic signed [31:0]                     filtered_height_out,
	output logic signed [31:0]                     filtered_velocity_out
);

	localparam longint unsigned Depth   = longint'(SINE_TABLE_DEPTH);
	localparam longint unsigned PhQ     = 65536 / Depth;
	localparam longint unsigned PhRem   = 65536 % Depth;
	localparam longint unsigned RecipC  = ((PhRem << 32) + Depth - 1) / Depth;

	localparam int unsigned PW = stpd_pkg::PROD_W;
	localparam int unsigned OW = stpd_pkg::OPND_W;

	logic [30:0]        pos_scale_q, p_scale_q, d_scale_q, amp_q, cur_scale_q;
	logic signed [31:0] offset_q, center_q;
	logic signed [31:0] fh_q, fv_q;

	logic signed [31:0] pos_q, vel_q;
	logic [15:0]        sa_q, sb_q, ph_q;
	logic [15:0]        k_q, f_q;
	logic [1:0]         quad_q;
	logic [16:0]        x_q, x2_q, t_q;
	logic signed [17:0] sin_q, cos_q;
	logic signed [31:0] dh_q, dv_q, eh_q, ev_q, u_q, iq_q;
	logic [32:0]        api_q;
	logic [30:0]        pg_q, dg_q;
	logic signed [48:0] acc_q;

	logic signed [31:0] cmd_out_q, fh_out_q, fv_out_q;

	logic signed [OW-1:0] op_a, op_b;
	logic signed [PW-1:0] prod, prod_sh;
	logic [15:0]          ph_sel;
	logic [15:0]          a_sum;
	logic [14:0]          r_adj;
	logic [16:0]          mid17, s_clamp;
	logic signed [17:0]   trig_val;
	logic signed [PW-1:0] fh_sum, fv_sum;

	assign ph_sel  = cmd.pass ? ph_q : ph_q - stpd_pkg::QUARTER_TURN;
	assign prod    = op_a * op_b;
	assign prod_sh = prod >>> 16;
	assign mid17   = prod[32:16];
	assign a_sum   = prod[15:0] + f_q;
	assign r_adj   = a_sum[14] ? stpd_pkg::QUARTER_R - {1'b0, a_sum[13:0]}
	                           : {1'b0, a_sum[13:0]};
	assign s_clamp = (mid17 > stpd_pkg::SINE_ONE) ? stpd_pkg::SINE_ONE : mid17;
	assign trig_val = quad_q[1] ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});
	assign fh_sum  = (prod_sh + PW'(fh_q)) >>> 1;
	assign fv_sum  = (prod_sh + PW'(fv_q)) >>> 1;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.step)
			stpd_pkg::ST_FH: begin
				op_a = $signed({3'b000, pos_scale_q});
				op_b = OW'(pos_q);
			end
			stpd_pkg::ST_FV: begin
				op_a = $signed({3'b000, pos_scale_q});
				op_b = OW'(vel_q);
			end
			stpd_pkg::ST_K: begin
				op_a = $signed({18'd0, ph_sel});
				op_b = $signed(OW'(Depth));
			end
			stpd_pkg::ST_F: begin
				op_a = $signed({18'd0, k_q});
				op_b = $signed(OW'(RecipC));
			end
			stpd_pkg::ST_A: begin
				op_a = $signed({18'd0, k_q});
				op_b = $signed(OW'(PhQ));
			end
			stpd_pkg::ST_X2: begin
				op_a = $signed({17'd0, x_q});
				op_b = $signed({17'd0, x_q});
			end
			stpd_pkg::ST_H1, stpd_pkg::ST_H2, stpd_pkg::ST_H3, stpd_pkg::ST_H4: begin
				op_a = $signed({17'd0, x2_q});
				op_b = $signed({17'd0, t_q});
			end
			stpd_pkg::ST_S: begin
				op_a = $signed({17'd0, x_q});
				op_b = $signed({17'd0, t_q});
			end
			stpd_pkg::ST_DH: begin
				op_a = $signed({3'b000, amp_q});
				op_b = OW'(sin_q);
			end
			stpd_pkg::ST_API: begin
				op_a = $signed({3'b000, amp_q});
				op_b = $signed({16'd0, stpd_pkg::PI_Q16});
			end
			stpd_pkg::ST_DV: begin
				op_a = $signed({1'b0, api_q});
				op_b = OW'(cos_q);
			end
			stpd_pkg::ST_PG: begin
				op_a = $signed({3'b000, p_scale_q});
				op_b = $signed({18'd0, sa_q});
			end
			stpd_pkg::ST_DG: begin
				op_a = $signed({3'b000, d_scale_q});
				op_b = $signed({18'd0, sb_q});
			end
			stpd_pkg::ST_PE: begin
				op_a = $signed({3'b000, pg_q});
				op_b = OW'(eh_q);
			end
			stpd_pkg::ST_DE: begin
				op_a = $signed({3'b000, dg_q});
				op_b = OW'(ev_q);
			end
			stpd_pkg::ST_IQ: begin
				op_a = OW'(u_q);
				op_b = $signed({3'b000, cur_scale_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_scale_q <= stpd_pkg::RST_POSITION_SCALE;
			p_scale_q   <= stpd_pkg::RST_P_GAIN_SCALE;
			d_scale_q   <= stpd_pkg::RST_D_GAIN_SCALE;
			offset_q    <= stpd_pkg::RST_EFFORT_OFFSET;
			center_q    <= stpd_pkg::RST_REFERENCE_CENTER;
			amp_q       <= stpd_pkg::RST_REFERENCE_AMPLITUDE;
			cur_scale_q <= stpd_pkg::RST_CURRENT_SCALE;
			fh_q        <= '0;
			fv_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					stpd_pkg::CFG_POSITION_SCALE:      pos_scale_q <= cfg_wdata[30:0];
					stpd_pkg::CFG_P_GAIN_SCALE:        p_scale_q   <= cfg_wdata[30:0];
					stpd_pkg::CFG_D_GAIN_SCALE:        d_scale_q   <= cfg_wdata[30:0];
					stpd_pkg::CFG_EFFORT_OFFSET:       offset_q    <= $signed(cfg_wdata);
					stpd_pkg::CFG_REFERENCE_CENTER:    center_q    <= $signed(cfg_wdata);
					stpd_pkg::CFG_REFERENCE_AMPLITUDE: amp_q       <= cfg_wdata[30:0];
					stpd_pkg::CFG_CURRENT_SCALE:       cur_scale_q <= cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (cmd.run && cmd.step == stpd_pkg::ST_FH) begin
				fh_q <= stpd_pkg::sat32(fh_sum);
			end
			if (cmd.run && cmd.step == stpd_pkg::ST_FV) begin
				fv_q <= stpd_pkg::sat32(fv_sum);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= motor_position;
			vel_q <= motor_velocity;
			sa_q  <= slider_a;
			sb_q  <= slider_b;
			ph_q  <= trajectory_phase;
		end
		if (cmd.load_out) begin
			cmd_out_q <= iq_q;
			fh_out_q  <= fh_q;
			fv_out_q  <= fv_q;
		end
		if (cmd.run) begin
			case (cmd.step)
				stpd_pkg::ST_K: k_q <= prod[31:16];
				stpd_pkg::ST_F: f_q <= prod[47:32];
				stpd_pkg::ST_A: begin
					quad_q <= a_sum[15:14];
					x_q    <= {r_adj, 2'b00};
				end
				stpd_pkg::ST_X2: begin
					x2_q <= mid17;
					t_q  <= stpd_pkg::SINE_C0;
				end
				stpd_pkg::ST_H1: t_q <= stpd_pkg::SINE_C1 - mid17;
				stpd_pkg::ST_H2: t_q <= stpd_pkg::SINE_C2 - mid17;
				stpd_pkg::ST_H3: t_q <= stpd_pkg::SINE_C3 - mid17;
				stpd_pkg::ST_H4: t_q <= stpd_pkg::SINE_C4 - mid17;
				stpd_pkg::ST_S: begin
					if (cmd.pass) begin
						cos_q <= trig_val;
					end else begin
						sin_q <= trig_val;
					end
				end
				stpd_pkg::ST_DH:  dh_q  <= stpd_pkg::sat32(prod_sh + PW'(center_q));
				stpd_pkg::ST_API: api_q <= prod[48:16];
				stpd_pkg::ST_DV:  dv_q  <= stpd_pkg::sat32(prod_sh);
				stpd_pkg::ST_PG: begin
					pg_q <= prod[46:16];
					eh_q <= stpd_pkg::sat32(PW'(dh_q) - PW'(fh_q));
					ev_q <= stpd_pkg::sat32(PW'(dv_q) - PW'(fv_q));
				end
				stpd_pkg::ST_DG:  dg_q  <= prod[46:16];
				stpd_pkg::ST_PE:  acc_q <= 49'(prod_sh + PW'(offset_q));
				stpd_pkg::ST_DE:  u_q   <= stpd_pkg::sat32(PW'(acc_q) + prod_sh);
				stpd_pkg::ST_IQ:  iq_q  <= stpd_pkg::sat32(prod_sh);
				default: ;
			endcase
		end
	end

	assign current_command       = cmd_out_q;
	assign filtered_height_out   = fh_out_q;
	assign filtered_velocity_out = fv_out_q;

endmodule

// ===== rtl/sine_tracking_pd_current_loop_unit.sv =====
// ----------------------------------------------------------------------------
// sine_tracking_pd_current_loop_unit
// PD current loop tracking a sine height reference, signed Q16.16. Filters
// motor position and velocity, builds the reference from a quarter-wave sine
// polynomial and issues a saturated current command.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   cfg     | cfg_we               | cfg_index, cfg_wdata
//   in      | in_valid / in_ready  | motor_ready, motor_position,
//           |                      | motor_velocity, slider_a, slider_b,
//           |                      | trajectory_phase
//   out     | out_valid / out_ready| current_command, filtered_height_out,
//           |                      | filtered_velocity_out
//
// A transfer with motor_ready high runs 28 steps through the one shared
// 34x34 multiplier, then a load into the output register, before in_ready
// rises again. A transfer with motor_ready low is accepted with no result.
// Reset clears the filter state and loads register defaults. A stalled
// output holds its register; the next item runs and then waits for the
// register to free up.
// ----------------------------------------------------------------------------
module sine_tracking_pd_current_loop_unit #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [stpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              motor_ready,
	input  logic signed [31:0]                motor_position,
	input  logic signed [31:0]                motor_velocity,
	input  logic [15:0]                       slider_a,
	input  logic [15:0]                       slider_b,
	input  logic [15:0]                       trajectory_phase,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                current_command,
	output logic signed [31:0]                filtered_height_out,
	output logic signed [31:0]                filtered_velocity_out
);

	stpd_pkg::cmd_t cmd;

	stpd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.motor_ready (motor_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd         (cmd)
	);

	stpd_datapath #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_datapath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_wdata             (cfg_wdata),
		.cmd                   (cmd),
		.motor_position        (motor_position),
		.motor_velocity        (motor_velocity),
		.slider_a              (slider_a),
		.slider_b              (slider_b),
		.trajectory_phase      (trajectory_phase),
		.current_command       (current_command),
		.filtered_height_out   (filtered_height_out),
		.filtered_velocity_out (filtered_velocity_out)
	);

endmodule
